[rtl/awcd_pkg.sv]
// Shared types, widths and reset values for the ADC window change detector.
package awcd_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int RUN_BITS_DEF    = 8;

	localparam int THR_W      = 7;
	localparam int CNT_W      = 8;
	localparam int AVG_W      = 16;
	localparam int SUM_W      = 28;
	localparam int ACC_W      = 29;
	localparam int CFG_DATA_W = 16;
	localparam int REG_IDX_W  = 2;

	localparam logic [THR_W-1:0] THRESHOLD_RST    = THR_W'(4);
	localparam logic [CNT_W-1:0] WINDOW_COUNT_RST = CNT_W'(4);
	localparam logic [CNT_W-1:0] SAME_COUNT_RST   = CNT_W'(6);
	localparam logic [AVG_W-1:0] AVG_SAMPLES_RST  = AVG_W'(5000);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_THRESHOLD    = 2'd0,
		REG_WINDOW_COUNT = 2'd1,
		REG_SAME_COUNT   = 2'd2,
		REG_AVG_SAMPLES  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0] threshold;
		logic [CNT_W-1:0] window_count;
		logic [CNT_W-1:0] same_count;
		logic [AVG_W-1:0] avg_samples;
	} cfg_t;

endpackage

[rtl/awcd_if.sv]
// Request channel interfaces: converter samples in, detector results out.
interface awcd_in_if
	import awcd_pkg::*;
	#(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface awcd_out_if
	import awcd_pkg::*;
	#(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);
	logic                   valid;
	logic                   ready;
	logic                   changed;
	logic [SAMPLE_BITS-1:0] change_value;
	logic [SAMPLE_BITS-1:0] win_low;
	logic [SAMPLE_BITS-1:0] win_high;
	logic                   sum_ready;
	logic [SUM_W-1:0]       sample_sum;

	modport source (output valid, output changed, output change_value, output win_low,
		output win_high, output sum_ready, output sample_sum, input ready);
	modport sink   (input valid, input changed, input change_value, input win_low,
		input win_high, input sum_ready, input sample_sum, output ready);
endinterface

[rtl/adc_window_change_detector.sv]
// Top level of the ADC window change detector with running sample sum.
//
// A request on adc is captured in an input register (stage 1); when stage 2
// is free, the window tracker and the summer update their state from it and
// the result register (stage 2) takes the outcome. Each sample passes the
// stage 1 and stage 2 registers; sustained rate is one sample per cycle as
// long as result.ready keeps up. A stalled result holds stage 2 and stage 1
// still takes one more request, so back-pressure reaches adc.ready only
// when both stages are full. Configuration writes (wr_en/wr_index/wr_data)
// take effect at once; write them only while no request is in flight.
// Writing the threshold reloads the window to [0, threshold].
module adc_window_change_detector
	import awcd_pkg::*;
	#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int RUN_BITS    = RUN_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	awcd_in_if.sink               adc,
	awcd_out_if.source            result
);

	cfg_t cfg_q;
	logic reload;

	// stage 1: captured sample
	logic                   vld_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;

	// stage 2: result register
	logic                   vld_s2;
	logic                   changed_s2;
	logic [SAMPLE_BITS-1:0] change_value_s2, win_low_s2, win_high_s2;
	logic                   sum_ready_s2;
	logic [SUM_W-1:0]       sample_sum_s2;

	logic                   adv_s2, step;
	logic                   chg;
	logic [SAMPLE_BITS-1:0] lo_next, hi_next;
	logic                   sum_rdy;
	logic [SUM_W-1:0]       sum_val;

	// stage 2 frees when empty or drained; stage 1 frees when empty or moving
	assign adv_s2    = !vld_s2 || result.ready;
	assign step      = vld_s1 && adv_s2;
	assign adc.ready = !vld_s1 || adv_s2;
	assign reload    = wr_en && (reg_idx_t'(wr_index) == REG_THRESHOLD);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold    <= THRESHOLD_RST;
			cfg_q.window_count <= WINDOW_COUNT_RST;
			cfg_q.same_count   <= SAME_COUNT_RST;
			cfg_q.avg_samples  <= AVG_SAMPLES_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_THRESHOLD:    cfg_q.threshold    <= wr_data[THR_W-1:0];
				REG_WINDOW_COUNT: cfg_q.window_count <= wr_data[CNT_W-1:0];
				REG_SAME_COUNT:   cfg_q.same_count   <= wr_data[CNT_W-1:0];
				REG_AVG_SAMPLES:  cfg_q.avg_samples  <= wr_data[AVG_W-1:0];
				default: ;
			endcase
		end
	end

	// the window tracker sees the new threshold in the same cycle as the reload
	cfg_t cfg_eff;
	always_comb begin
		cfg_eff = cfg_q;
		if (reload) begin
			cfg_eff.threshold = wr_data[THR_W-1:0];
		end
	end

	awcd_window #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.RUN_BITS   (RUN_BITS)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_eff),
		.reload (reload),
		.step   (step),
		.sample (sample_s1),
		.changed(chg),
		.lo_next(lo_next),
		.hi_next(hi_next)
	);

	awcd_sum #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.step      (step),
		.sample    (sample_s1),
		.sum_ready (sum_rdy),
		.sample_sum(sum_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adc.ready) begin
			vld_s1 <= adc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adc.valid && adc.ready) begin
			sample_s1 <= adc.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			changed_s2      <= chg;
			change_value_s2 <= chg ? sample_s1 : '0;
			win_low_s2      <= lo_next;
			win_high_s2     <= hi_next;
			sum_ready_s2    <= sum_rdy;
			sample_sum_s2   <= sum_val;
		end
	end

	assign result.valid        = vld_s2;
	assign result.changed      = changed_s2;
	assign result.change_value = change_value_s2;
	assign result.win_low      = win_low_s2;
	assign result.win_high     = win_high_s2;
	assign result.sum_ready    = sum_ready_s2;
	assign result.sample_sum   = sample_sum_s2;

`ifndef ASSERT_OFF
	a_step_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> vld_s2)
		else $error("stage 1 moved but stage 2 is empty");

	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (win_low_s2 <= win_high_s2))
		else $error("window low bound above high bound");

	a_change_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !changed_s2) |-> (change_value_s2 == '0))
		else $error("change value set without a change");

	a_sum_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !sum_ready_s2) |-> (sample_sum_s2 == '0))
		else $error("sample sum set without sum ready");
`endif

endmodule

[rtl/awcd_window.sv]
// Window tracking: outside/settled run counters, recentring and change flag.
module awcd_window
	import awcd_pkg::*;
	#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int RUN_BITS    = RUN_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   reload,
	input  logic                   step,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   changed,
	output logic [SAMPLE_BITS-1:0] lo_next,
	output logic [SAMPLE_BITS-1:0] hi_next
);

	localparam int CW = (RUN_BITS > CNT_W) ? RUN_BITS : CNT_W;
	localparam logic [RUN_BITS-1:0]    RUN_MAX    = {RUN_BITS{1'b1}};
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

	logic [SAMPLE_BITS-1:0] lo_q, hi_q;
	logic [RUN_BITS-1:0]    orun_q, srun_q;

	logic [SAMPLE_BITS-1:0] thr;
	logic [SAMPLE_BITS:0]   hi_sum;
	logic [RUN_BITS-1:0]    orun_inc, srun_inc, orun_next, srun_next;
	logic                   outside, recentre;

	always_comb begin
		thr      = SAMPLE_BITS'(cfg.threshold);
		outside  = (sample < lo_q) || (sample > hi_q);
		orun_inc = (orun_q != RUN_MAX) ? orun_q + 1'b1 : orun_q;
		srun_inc = (srun_q != RUN_MAX) ? srun_q + 1'b1 : srun_q;
		recentre = outside && (CW'(orun_inc) >= CW'(cfg.window_count));
		hi_sum   = {1'b0, sample} + {1'b0, thr};

		lo_next   = lo_q;
		hi_next   = hi_q;
		orun_next = orun_q;
		srun_next = srun_q;
		if (outside) begin
			orun_next = orun_inc;
			if (recentre) begin
				orun_next = '0;
				srun_next = '0;
				lo_next   = (sample >= thr) ? sample - thr : '0;
				hi_next   = hi_sum[SAMPLE_BITS] ? SAMPLE_MAX : hi_sum[SAMPLE_BITS-1:0];
			end
		end else begin
			orun_next = '0;
			srun_next = srun_inc;
		end
		changed = (CW'(srun_next) == CW'(cfg.same_count));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q   <= '0;
			hi_q   <= SAMPLE_BITS'(THRESHOLD_RST);
			orun_q <= '0;
			srun_q <= '0;
		end else if (reload) begin
			// threshold write: window reloads, counters stay
			lo_q <= '0;
			hi_q <= thr;
		end else if (step) begin
			lo_q   <= lo_next;
			hi_q   <= hi_next;
			orun_q <= orun_next;
			srun_q <= srun_next;
		end
	end

endmodule

[rtl/awcd_sum.sv]
// Running sample sum, output every max(1,avg_samples) samples.
module awcd_sum
	import awcd_pkg::*;
	#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   step,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   sum_ready,
	output logic [SUM_W-1:0]       sample_sum
);

	logic [ACC_W-1:0] acc_q, acc_next, acc_add;
	logic [AVG_W-1:0] idx_q, idx_next, idx_add;
	logic             bypass;

	always_comb begin
		bypass     = (cfg.avg_samples <= AVG_W'(1));
		acc_add    = acc_q + ACC_W'(sample);
		idx_add    = idx_q + 1'b1;
		acc_next   = acc_q;
		idx_next   = idx_q;
		sum_ready  = 1'b0;
		sample_sum = '0;
		if (bypass) begin
			sum_ready  = 1'b1;
			sample_sum = SUM_W'(sample);
		end else if (idx_add >= cfg.avg_samples) begin
			sum_ready  = 1'b1;
			sample_sum = acc_add[SUM_W-1:0];
			acc_next   = '0;
			idx_next   = '0;
		end else begin
			acc_next = acc_add;
			idx_next = idx_add;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			idx_q <= '0;
		end else if (step) begin
			acc_q <= acc_next;
			idx_q <= idx_next;
		end
	end

endmodule
